### hdl/assert_macros.svh
// Assertion helpers, clocked on clock and quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge.
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequent must hold in the cycle of the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### hdl/kwm_pkg.sv
package kwm_pkg;

   localparam int MaxSources = 16;
   localparam int IdxW       = $clog2(MaxSources);
   localparam int SizeW      = $clog2(MaxSources + 1);
   localparam int KidW       = IdxW + 2;
   localparam int CountW     = 16;
   localparam int OrdW       = 40;

   localparam logic [CountW-1:0] ChunkReset = 16'd1024;

   // Field order makes a plain unsigned compare the merge order.
   typedef struct packed {
      logic [15:0] ref_index;
      logic [31:0] position;
      logic [3:0]  source;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

   typedef enum logic [1:0] {
      FUNC_ADD     = 2'd0,
      FUNC_REPLACE = 2'd1,
      FUNC_REMOVE  = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [3:0]        min_source;
      logic [15:0]       min_ref_index;
      logic [31:0]       min_position;
      logic              heap_empty;
      status_type        status;
      logic              chunk_end;
      logic [CountW-1:0] chunk_count;
      logic [OrdW-1:0]   chunk_ordinal;
   } rsp_type;

endpackage

### hdl/kwm_ram.sv
module kwm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/kway_merge_min_heap.sv
// Channel   Dir   Handshake          Word
// req_      in    valid / stall      func, ref_index, position, source
// rsp_      out   valid / stall      min entry, empty, status, chunk info
// csr_      in    write_enable       records_per_chunk
//
// One item at a time; req_stall is high from accept until the result is loaded.
// Add runs S_ADD_UP, S_ADD_CMP per level climbed; replace runs S_DN_RD1, S_DN_CMP1, S_DN_CMP2
// (if a second child exists), S_DN_RES per level; remove also fetches the last entry first.
// The sift runs on one comparator and a one-read, one-write heap RAM.
// Reset clears size, chunk counters and the chunk size (1024); the RAM is not cleared.
// A stalled result holds in the output register; the sequencer waits before loading.
module kway_merge_min_heap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_ref_index,
   input  logic [31:0] req_position,
   input  logic [3:0]  req_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_min_source,
   output logic [15:0] rsp_min_ref_index,
   output logic [31:0] rsp_min_position,
   output logic        rsp_heap_empty,
   output logic [1:0]  rsp_status,
   output logic        rsp_chunk_end,
   output logic [15:0] rsp_chunk_count,
   output logic [39:0] rsp_chunk_ordinal,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_UP,
      S_ADD_CMP,
      S_DN_LOAD,
      S_DN_RD1,
      S_DN_CMP1,
      S_DN_CMP2,
      S_DN_RES,
      S_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [kwm_pkg::SizeW-1:0]    size_ff, size_in;
   logic [kwm_pkg::IdxW-1:0]     idx_ff, idx_in;
   logic [kwm_pkg::IdxW-1:0]     best_idx_ff, best_idx_in;
   kwm_pkg::entry_type           mov_ff, mov_in;
   kwm_pkg::entry_type           best_ff, best_in;
   kwm_pkg::entry_type           root_ff, root_in;
   kwm_pkg::status_type          status_ff, status_in;
   logic                         counted_ff, counted_in;
   logic [kwm_pkg::CountW-1:0]   fill_ff, fill_in;
   logic [kwm_pkg::OrdW-1:0]     ord_ff, ord_in;
   logic [kwm_pkg::CountW-1:0]   chunk_size_ff, chunk_size_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kwm_pkg::rsp_type             rsp_ff, rsp_in;

   logic                         ram_we;
   logic [kwm_pkg::IdxW-1:0]     ram_waddr;
   kwm_pkg::entry_type           ram_wdata;
   logic [kwm_pkg::IdxW-1:0]     ram_raddr;
   logic [kwm_pkg::EntryW-1:0]   ram_rdata_raw;
   kwm_pkg::entry_type           ram_rdata;

   kwm_pkg::entry_type           cmp_a, cmp_b;
   logic                         cmp_less;

   logic [kwm_pkg::IdxW-1:0]     parent_idx;
   logic [kwm_pkg::KidW-1:0]     kid1, kid2, size_wide;
   logic [kwm_pkg::CountW-1:0]   limit, fill_next;
   logic                         close_chunk;
   kwm_pkg::entry_type           req_entry;

   kwm_ram #(
      .Width (kwm_pkg::EntryW),
      .Depth (kwm_pkg::MaxSources)
   ) u_heap_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = kwm_pkg::entry_type'(ram_rdata_raw);

   assign req_entry  = '{ref_index: req_ref_index, position: req_position, source: req_source};
   assign parent_idx = (idx_ff - kwm_pkg::IdxW'(1)) >> 1;
   assign kid1       = {1'b0, idx_ff, 1'b1};
   assign kid2       = kid1 + kwm_pkg::KidW'(1);
   assign size_wide  = kwm_pkg::KidW'(size_ff);

   // Shared comparator: a strictly before b in merge order.
   always_comb begin
      cmp_a = ram_rdata;
      cmp_b = mov_ff;
      unique case (state_ff)
         S_ADD_CMP: begin
            cmp_a = mov_ff;
            cmp_b = ram_rdata;
         end
         S_DN_CMP2: cmp_b = best_ff;
         default:   cmp_b = mov_ff;
      endcase
   end

   assign cmp_less = cmp_a < cmp_b;

   assign limit       = (chunk_size_ff == '0) ? kwm_pkg::CountW'(1) : chunk_size_ff;
   assign fill_next   = fill_ff + kwm_pkg::CountW'(1);
   assign close_chunk = counted_ff &&
                        ((fill_next == limit) || (size_ff == '0 && fill_next != '0));

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      best_idx_in   = best_idx_ff;
      mov_in        = mov_ff;
      best_in       = best_ff;
      status_in     = status_ff;
      counted_in    = counted_ff;
      fill_in       = fill_ff;
      ord_in        = ord_ff;
      chunk_size_in = csr_write_enable ? csr_write_data : chunk_size_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = mov_ff;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in  = kwm_pkg::STATUS_OK;
               counted_in = 1'b0;
               idx_in     = '0;
               unique case (kwm_pkg::func_type'(req_func)) inside
                  kwm_pkg::FUNC_ADD: begin
                     if (size_ff == kwm_pkg::SizeW'(kwm_pkg::MaxSources)) begin
                        status_in = kwm_pkg::STATUS_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        mov_in   = req_entry;
                        idx_in   = size_ff[kwm_pkg::IdxW-1:0];
                        size_in  = size_ff + kwm_pkg::SizeW'(1);
                        state_in = S_ADD_UP;
                     end
                  end
                  kwm_pkg::FUNC_REPLACE, kwm_pkg::FUNC_REMOVE: begin
                     if (size_ff == '0) begin
                        status_in = kwm_pkg::STATUS_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        counted_in = 1'b1;
                        if (req_func == kwm_pkg::FUNC_REPLACE) begin
                           mov_in   = '{ref_index: req_ref_index, position: req_position,
                                        source: root_ff.source};
                           state_in = S_DN_RD1;
                        end else begin
                           // fetch the last entry; it refills the root
                           size_in   = size_ff - kwm_pkg::SizeW'(1);
                           ram_raddr = kwm_pkg::IdxW'(size_ff - kwm_pkg::SizeW'(1));
                           state_in  = (size_ff == kwm_pkg::SizeW'(1)) ? S_FINISH
                                                                       : S_DN_LOAD;
                        end
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_ADD_UP: begin
            if (idx_ff == '0) begin
               ram_we   = 1'b1;
               state_in = S_FINISH;
            end else begin
               ram_raddr = parent_idx;
               state_in  = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            ram_we = 1'b1;
            if (cmp_less) begin
               // pull the parent down into the hole and climb
               ram_wdata = ram_rdata;
               idx_in    = parent_idx;
               state_in  = S_ADD_UP;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DN_LOAD: begin
            mov_in   = ram_rdata;
            state_in = S_DN_RD1;
         end
         S_DN_RD1: begin
            if (kid1 < size_wide) begin
               ram_raddr = kid1[kwm_pkg::IdxW-1:0];
               state_in  = S_DN_CMP1;
            end else begin
               ram_we   = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_DN_CMP1: begin
            if (cmp_less) begin
               best_in     = ram_rdata;
               best_idx_in = kid1[kwm_pkg::IdxW-1:0];
            end else begin
               best_in     = mov_ff;
               best_idx_in = idx_ff;
            end
            if (kid2 < size_wide) begin
               ram_raddr = kid2[kwm_pkg::IdxW-1:0];
               state_in  = S_DN_CMP2;
            end else begin
               state_in = S_DN_RES;
            end
         end
         S_DN_CMP2: begin
            if (cmp_less) begin
               best_in     = ram_rdata;
               best_idx_in = kid2[kwm_pkg::IdxW-1:0];
            end
            state_in = S_DN_RES;
         end
         S_DN_RES: begin
            ram_we = 1'b1;
            if (best_idx_ff == idx_ff) begin
               state_in = S_FINISH;
            end else begin
               // move the smaller child up and descend
               ram_wdata = best_ff;
               idx_in    = best_idx_ff;
               state_in  = S_DN_RD1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.heap_empty    = (size_ff == '0);
               rsp_in.min_source    = (size_ff == '0) ? '0 : root_ff.source;
               rsp_in.min_ref_index = (size_ff == '0) ? '0 : root_ff.ref_index;
               rsp_in.min_position  = (size_ff == '0) ? '0 : root_ff.position;
               rsp_in.status        = status_ff;
               rsp_in.chunk_end     = close_chunk;
               rsp_in.chunk_count   = close_chunk ? fill_next : '0;
               rsp_in.chunk_ordinal = close_chunk ? ord_ff : '0;
               if (counted_ff) begin
                  fill_in = close_chunk ? '0 : fill_next;
               end
               if (close_chunk) begin
                  ord_in = ord_ff + kwm_pkg::OrdW'(fill_next);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Keep a copy of slot 0 for the result and for replace.
   always_comb begin
      root_in = root_ff;
      if (ram_we && ram_waddr == '0) begin
         root_in = ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         size_ff       <= '0;
         fill_ff       <= '0;
         ord_ff        <= '0;
         chunk_size_ff <= kwm_pkg::ChunkReset;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         size_ff       <= size_in;
         fill_ff       <= fill_in;
         ord_ff        <= ord_in;
         chunk_size_ff <= chunk_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      mov_ff      <= mov_in;
      best_ff     <= best_in;
      root_ff     <= root_in;
      status_ff   <= status_in;
      counted_ff  <= counted_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_source    = rsp_ff.min_source;
   assign rsp_min_ref_index = rsp_ff.min_ref_index;
   assign rsp_min_position  = rsp_ff.min_position;
   assign rsp_heap_empty    = rsp_ff.heap_empty;
   assign rsp_status        = rsp_ff.status;
   assign rsp_chunk_end     = rsp_ff.chunk_end;
   assign rsp_chunk_count   = rsp_ff.chunk_count;
   assign rsp_chunk_ordinal = rsp_ff.chunk_ordinal;

   `ASSERT_ALWAYS(a_size_bound, size_ff <= kwm_pkg::SizeW'(kwm_pkg::MaxSources), "heap size over capacity")
   `ASSERT_IMPLIES(a_no_write_idle, state_ff == S_IDLE || state_ff == S_FINISH, !ram_we, "heap write outside sift")
   `ASSERT_IMPLIES(a_chunk_nonzero, rsp_valid_ff && rsp_ff.chunk_end, rsp_ff.chunk_count != '0, "empty chunk closed")
   `ASSERT_IMPLIES(a_error_no_chunk, rsp_valid_ff && rsp_ff.status != kwm_pkg::STATUS_OK, !rsp_ff.chunk_end, "error closed a chunk")

endmodule
